// ===== hdl/bale_pkg.sv =====
// Shared types and constants for the bounded array list engine.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package bale_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int VAL_W  = 64;
	localparam int QDEPTH = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_READ   = 3'd5,
		OP_WRITE  = 3'd6,
		OP_RESIZE = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_INDEX = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_BAD_SIZE  = 3'd4
	} status_t;

	// one classified request as it travels from front to back
	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} req_t;

endpackage

`default_nettype wire

// ===== hdl/bale_front.sv =====
// Front end: accepts input beats, decodes the mode into an operation
// and holds the request in one register. Uses bale_pkg.
`default_nettype none

module bale_front
	import bale_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       in_mode,
	input  wire logic [CNT_W-1:0] in_pos,
	input  wire logic [VAL_W-1:0] in_val,
	output logic                  req_valid,
	input  wire logic             req_ready,
	output req_t                  req
);

	logic valid_s1;
	req_t req_s1;
	op_t  op_dec;

	// the mode field carries the operation code directly
	assign op_dec = op_t'(in_mode);

	assign in_ready  = !valid_s1 || req_ready;
	assign req_valid = valid_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.op  <= op_dec;
			req_s1.pos <= in_pos;
			req_s1.val <= in_val;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bale_fifo.sv =====
// Short request queue between front and back end.
// Depth QDEPTH from bale_pkg; carries req_t.
`default_nettype none

module bale_fifo
	import bale_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  req_t      push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output req_t      pop_data
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int OCC_W = $clog2(QDEPTH + 1);

	req_t             slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             push;
	logic             pop;

	assign push_ready = (occ_q != OCC_W'(QDEPTH));
	assign pop_valid  = (occ_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bale_back.sv =====
// Back end: the entry cell row, fill count, capacity register and the
// result register. Executes one request per cycle when not stalled. Uses bale_pkg.
`default_nettype none

module bale_back
	import bale_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic [VAL_W-1:0]      res_data,
	output status_t               res_status,
	output logic [CNT_W-1:0]      res_count
);

	logic [VAL_W-1:0] cell_q [DEPTH];
	logic [VAL_W-1:0] cell_d [DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] lim;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_data_q;
	status_t          out_status_q;
	logic [CNT_W-1:0] out_count_q;
	logic             go;
	status_t          st;
	logic             ok;
	logic             pos_bad;
	logic [IDX_W-1:0] pidx;
	logic [VAL_W-1:0] rd;

	assign lim       = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign req_ready = !out_valid_q || res_ready;
	assign go        = req_valid && req_ready;
	assign pos_bad   = (req.pos >= cnt_q);
	assign pidx      = req.pos[IDX_W-1:0];

	// status check
	always_comb begin
		unique case (req.op)
			OP_APPEND: st = (cnt_q >= lim) ? ST_FULL : ST_OK;
			OP_REMOVE: st = (cnt_q == '0) ? ST_EMPTY : ST_OK;
			OP_INSERT: st = pos_bad ? ST_BAD_INDEX : ((cnt_q >= lim) ? ST_FULL : ST_OK);
			OP_ERASE,
			OP_READ,
			OP_WRITE:  st = pos_bad ? ST_BAD_INDEX : ST_OK;
			OP_CLEAR:  st = ST_OK;
			default:   st = (req.pos > lim) ? ST_BAD_SIZE : ST_OK;
		endcase
	end

	assign ok = (st == ST_OK);
	assign rd = (req.op == OP_READ && ok) ? cell_q[pidx] : '0;

	// Cells past the fill count are always zero, so shifts and clears can
	// act on the whole row without looking at the count.
	always_comb begin
		cnt_d = cnt_q;
		for (int i = 0; i < DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			if (ok) begin
				unique case (req.op)
					OP_APPEND: if (CNT_W'(i) == cnt_q) cell_d[i] = req.val;
					OP_REMOVE: if (CNT_W'(i) == cnt_q - CNT_W'(1)) cell_d[i] = '0;
					OP_INSERT: begin
						if (CNT_W'(i) == req.pos) begin
							cell_d[i] = req.val;
						end else if (CNT_W'(i) > req.pos) begin
							cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
						end
					end
					OP_ERASE: begin
						if (CNT_W'(i) >= req.pos) begin
							cell_d[i] = (i < DEPTH - 1) ? cell_q[(i < DEPTH - 1) ? i + 1 : i] : '0;
						end
					end
					OP_CLEAR: cell_d[i] = '0;
					OP_WRITE: if (CNT_W'(i) == req.pos) cell_d[i] = req.val;
					OP_RESIZE: if (CNT_W'(i) >= req.pos) cell_d[i] = '0;
					default: ;
				endcase
			end
		end
		if (ok) begin
			unique case (req.op)
				OP_APPEND,
				OP_INSERT: cnt_d = cnt_q + CNT_W'(1);
				OP_REMOVE,
				OP_ERASE:  cnt_d = cnt_q - CNT_W'(1);
				OP_CLEAR:  cnt_d = '0;
				OP_RESIZE: cnt_d = req.pos;
				default:   cnt_d = cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				cell_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (req_ready) begin
				out_valid_q <= req_valid;
			end
			if (go) begin
				cnt_q <= cnt_d;
				for (int i = 0; i < DEPTH; i++) begin
					cell_q[i] <= cell_d[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_data_q   <= rd;
			out_status_q <= st;
			out_count_q  <= cnt_d;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_data   = out_data_q;
	assign res_status = out_status_q;
	assign res_count  = out_count_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count above store depth");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != CNT_W'(DEPTH)) |-> (cell_q[DEPTH-1] == '0))
		else $error("last cell holds data while list is not full");

	a_fail_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !ok) |=> (cnt_q == $past(cnt_q)))
		else $error("failed request changed the fill count");

	a_append_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ok && req.op == OP_APPEND) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("append did not grow the list by one");
`endif

endmodule

`default_nettype wire

// ===== hdl/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: front end, request queue
// and back end. Depends on bale_pkg, bale_front, bale_fifo, bale_back.
//
// Channel  | Dir | Signals                      | Beat contents (low bit up)
// ---------+-----+------------------------------+--------------------------------------
// s_ (req) | in  | s_tvalid s_tready s_tdata/u  | tuser: mode; tdata: position, item_value
// m_ (res) | out | m_tvalid m_tready m_tdata/u  | tuser: status; tdata: read_data, fill_count
// cfg      | in  | cfg_we cfg_wdata             | capacity, written on any edge with cfg_we
//
// Flow: one request beat per cycle sustained while m_tready is high; the back end
// executes each request on a row of 64 entry registers that all shift at
// once. A request passes the front register, the queue and the result register.
// Reset clears the entry row, the fill count and all queues; capacity goes to 64.
// A stalled result side fills the result register, then the two-entry queue,
// then the front register before s_tready drops; no beat is lost or repeated.
`default_nettype none

module bounded_array_list_engine
	import bale_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// config: capacity
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	// request stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [71:0]      s_tdata,  // [6:0] position, [70:7] item_value, [71] zero
	input  wire logic [2:0]       s_tuser,  // [2:0] mode
	// result stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [71:0]           m_tdata,  // [63:0] read_data, [70:64] fill_count, [71] zero
	output logic [2:0]            m_tuser   // [2:0] status
);

	logic             fr_valid;
	logic             fr_ready;
	req_t             fr_req;
	logic             bk_valid;
	logic             bk_ready;
	req_t             bk_req;
	logic [VAL_W-1:0] res_data;
	status_t          res_status;
	logic [CNT_W-1:0] res_count;

	bale_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_pos    (s_tdata[CNT_W-1:0]),
		.in_val    (s_tdata[CNT_W+VAL_W-1:CNT_W]),
		.req_valid (fr_valid),
		.req_ready (fr_ready),
		.req       (fr_req)
	);

	// decouples classification from execution
	bale_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_req),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_req)
	);

	bale_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (bk_valid),
		.req_ready  (bk_ready),
		.req        (bk_req),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_data   (res_data),
		.res_status (res_status),
		.res_count  (res_count)
	);

	// pack the result beat; top bit is padding
	assign m_tdata = {1'b0, res_count, res_data};
	assign m_tuser = res_status;

endmodule

`default_nettype wire
